// ===== design/sha1he_pkg.sv =====
// Shared types and constants of the SHA-1 hash engine.
`default_nettype none

package sha1he_pkg;

    localparam int BYTE_COUNT_WIDTH = 61;
    localparam int LEN_BITS_WIDTH   = 64;
    localparam int ROUND_COUNT      = 80;

    typedef logic [4:0][31:0]  chain_t;
    typedef logic [15:0][31:0] window_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } abcde_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        AFTER_IDLE,
        AFTER_MARK,
        AFTER_ZERO,
        AFTER_EMIT
    } after_t;

    localparam chain_t SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

endpackage

`default_nettype wire

// ===== design/sha1he_round.sv =====
// One SHA-1 compression round: round function, constant select and word update.
`default_nettype none

module sha1he_round (
    input  sha1he_pkg::abcde_t cur,
    input  logic [31:0]        w,
    input  logic [6:0]         round,
    output sha1he_pkg::abcde_t nxt
);
    import sha1he_pkg::*;

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb
    begin
        if (round inside {[7'd0:7'd19]})
        begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = K_00_19;
        end
        else if (round inside {[7'd20:7'd39]})
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_20_39;
        end
        else if (round inside {[7'd40:7'd59]})
        begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = K_40_59;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_60_79;
        end
    end

    assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

    always_comb
    begin
        nxt.a = t;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

`default_nettype wire

// ===== design/sha1_hash_engine_core.sv =====
// Top level of the SHA-1 hash engine: byte intake, padding sequencer and digest output.
`default_nettype none

// SHA-1 of a byte stream, one byte per input transfer. A byte that does not
// complete a 64-byte block is shifted into the message window and counted. A
// byte that completes a block is taken in and then holds the input through 80
// rounds in the single shared round unit, one round per cycle, and the fold
// of the result into the chaining words. An item marked last then pads at one
// byte per cycle, if need be into a second padding block, compresses one or
// two blocks and offers the five digest words h0..h4 as five output
// transfers, one per cycle while the output is not stalled. No input is taken
// from the moment an item completes a block or ends a message until that block
// is folded in or the fifth digest word has been transferred; after a message
// the engine restarts from the initial vector.

module sha1_hash_engine_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        no_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import sha1he_pkg::*;

    state_t                        state_reg, state_next;
    after_t                        after_reg, after_next;
    logic [5:0]                    pos_reg, pos_next;
    logic                          ovf_reg, ovf_next;
    logic [2:0]                    len_idx_reg, len_idx_next;
    logic [6:0]                    round_reg, round_next;
    logic [2:0]                    word_idx_reg, word_idx_next;
    logic [BYTE_COUNT_WIDTH-1:0]   count_reg, count_next;
    chain_t                        chain_reg, chain_next;
    window_t                       window_reg, window_next;
    abcde_t                        abcde_reg, abcde_next;

    abcde_t                        round_out;
    logic [31:0]                   sched_new;
    logic [LEN_BITS_WIDTH-1:0]     len_bits;
    logic [7:0]                    len_byte;
    logic [519:0]                  byte_shift;
    logic [7:0]                    shift_byte;
    logic                          shift_en;
    logic                          in_xfer;
    logic                          out_xfer;

    sha1he_round u_round (
        .cur   (abcde_reg),
        .w     (window_reg[15]),
        .round (round_reg),
        .nxt   (round_out)
    );

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign sched_new = window_reg[2] ^ window_reg[7] ^ window_reg[13] ^ window_reg[15];
    assign len_bits  = LEN_BITS_WIDTH'(count_reg) << 3;
    assign len_byte  = len_bits[{3'(3'd7 - len_idx_reg), 3'b000} +: 8];
    assign byte_shift = {window_reg, shift_byte};

    always_comb
    begin
        state_next    = state_reg;
        after_next    = after_reg;
        pos_next      = pos_reg;
        ovf_next      = ovf_reg;
        len_idx_next  = len_idx_reg;
        round_next    = 7'd0;
        word_idx_next = word_idx_reg;
        count_next    = count_reg;
        chain_next    = chain_reg;
        abcde_next    = '{a: chain_reg[0], b: chain_reg[1], c: chain_reg[2],
                          d: chain_reg[3], e: chain_reg[4]};
        shift_byte    = 8'd0;
        shift_en      = 1'b0;
        window_next   = window_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (!no_byte)
                    begin
                        shift_byte = data_byte;
                        shift_en   = 1'b1;
                        count_next = count_reg + BYTE_COUNT_WIDTH'(1);
                        pos_next   = 6'(count_reg[5:0] + 6'd1);
                        if (count_reg[5:0] == 6'd63)
                        begin
                            state_next = ST_ROUND;
                            after_next = is_last ? AFTER_MARK : AFTER_IDLE;
                        end
                        else if (is_last)
                        begin
                            state_next = ST_PAD_MARK;
                        end
                    end
                    else if (is_last)
                    begin
                        pos_next   = count_reg[5:0];
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                shift_byte = PAD_MARK_BYTE;
                shift_en   = 1'b1;
                pos_next   = pos_reg + 6'd1;
                ovf_next   = 1'b0;
                if (pos_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                    after_next = AFTER_ZERO;
                end
                else if (pos_reg >= 6'd56)
                begin
                    ovf_next   = 1'b1;
                    state_next = ST_PAD_ZERO;
                end
                else if (pos_reg == 6'd55)
                begin
                    len_idx_next = 3'd0;
                    state_next   = ST_PAD_LEN;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                shift_en = 1'b1;
                pos_next = pos_reg + 6'd1;
                if (ovf_reg && pos_reg == 6'd63)
                begin
                    ovf_next   = 1'b0;
                    state_next = ST_ROUND;
                    after_next = AFTER_ZERO;
                end
                else if (!ovf_reg && pos_reg == 6'd55)
                begin
                    len_idx_next = 3'd0;
                    state_next   = ST_PAD_LEN;
                end
            end
            ST_PAD_LEN:
            begin
                shift_byte   = len_byte;
                shift_en     = 1'b1;
                len_idx_next = len_idx_reg + 3'd1;
                if (len_idx_reg == 3'd7)
                begin
                    state_next = ST_ROUND;
                    after_next = AFTER_EMIT;
                end
            end
            ST_ROUND:
            begin
                abcde_next  = round_out;
                window_next = {window_reg[14:0], {sched_new[30:0], sched_new[31]}};
                round_next  = round_reg + 7'd1;
                if (round_reg == 7'(ROUND_COUNT - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                chain_next[0] = chain_reg[0] + abcde_reg.a;
                chain_next[1] = chain_reg[1] + abcde_reg.b;
                chain_next[2] = chain_reg[2] + abcde_reg.c;
                chain_next[3] = chain_reg[3] + abcde_reg.d;
                chain_next[4] = chain_reg[4] + abcde_reg.e;
                case (after_reg)
                    AFTER_IDLE: state_next = ST_IDLE;
                    AFTER_MARK:
                    begin
                        pos_next   = 6'd0;
                        state_next = ST_PAD_MARK;
                    end
                    AFTER_ZERO:
                    begin
                        pos_next   = 6'd0;
                        ovf_next   = 1'b0;
                        state_next = ST_PAD_ZERO;
                    end
                    AFTER_EMIT:
                    begin
                        word_idx_next = 3'd0;
                        state_next    = ST_EMIT;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (word_idx_reg == 3'd4)
                    begin
                        chain_next = SHA1_IV;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_idx_next = word_idx_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (shift_en)
        begin
            window_next = byte_shift[511:0];
        end
    end

    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        out_valid   = (state_reg == ST_EMIT);
        word_index  = word_idx_reg;
        last_word   = (word_idx_reg == 3'd4);
        case (word_idx_reg)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            after_reg    <= AFTER_IDLE;
            pos_reg      <= 6'd0;
            ovf_reg      <= 1'b0;
            len_idx_reg  <= 3'd0;
            round_reg    <= 7'd0;
            word_idx_reg <= 3'd0;
            count_reg    <= '0;
            chain_reg    <= SHA1_IV;
        end
        else
        begin
            state_reg    <= state_next;
            after_reg    <= after_next;
            pos_reg      <= pos_next;
            ovf_reg      <= ovf_next;
            len_idx_reg  <= len_idx_next;
            round_reg    <= round_next;
            word_idx_reg <= word_idx_next;
            count_reg    <= count_next;
            chain_reg    <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        abcde_reg  <= abcde_next;
    end

endmodule

`default_nettype wire

// ===== tb/sha1_hash_engine_core_tb.sv =====
// Testbench of the SHA-1 hash engine core: byte messages in, digest words checked.
`timescale 1ns / 1ps

module sha1_hash_engine_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 300;
    localparam int RANDOM_BYTES = 140;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int N_ROWS = 14;

    localparam logic [159:0] DIGEST_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] DIGEST_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    typedef enum int {
        MODE_STEADY,
        MODE_SENDER_GAPS,
        MODE_RECEIVER_STALLS,
        MODE_BOTH_IDLE
    } traffic_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         nb;
        logic         last;
        logic         typed;
        logic [159:0] digest;
    } row_t;

    localparam row_t DIRECTED_ROWS [N_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, DIGEST_EMPTY},
        '{8'hA5, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h61, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
        '{8'hFF, 1'b1, 1'b1, 1'b1, DIGEST_EMPTY},
        '{8'h00, 1'b0, 1'b1, 1'b0, 160'h0},
        '{8'hFF, 1'b0, 1'b1, 1'b0, 160'h0},
        '{8'h61, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h62, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h5A, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h63, 1'b0, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
        '{8'h55, 1'b0, 1'b1, 1'b0, 160'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        no_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    logic [31:0] chain [5];
    logic [7:0]  blk [64];
    logic [sha1he_pkg::BYTE_COUNT_WIDTH-1:0] nbytes;
    logic [159:0] digest_out;

    digest_word_t digest_q [$];
    traffic_t mode;
    bit hold_req = 1'b0;
    int errors = 0;
    int cycle_count = 0;

    sha1_hash_engine_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .no_byte    (no_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digest_word(digest_word),
        .word_index (word_index),
        .last_word  (last_word)
    );

    function automatic void restart_chain();
        chain[0] = 32'h67452301;
        chain[1] = 32'hEFCDAB89;
        chain[2] = 32'h98BADCFE;
        chain[3] = 32'h10325476;
        chain[4] = 32'hC3D2E1F0;
        nbytes = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 80; r++)
        begin
            t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {t[30:0], t[31]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    // Returns 1 when the item ends a message; the digest is then in digest_out.
    function automatic bit absorb_item(logic [7:0] d, logic nb, logic last);
        int unsigned pos;
        logic [63:0] bit_len;
        if (!nb)
        begin
            pos = 32'(nbytes[5:0]);
            blk[pos] = d;
            nbytes++;
            if (pos == 63)
                sha1_compress();
        end
        if (!last)
            return 1'b0;
        pos = 32'(nbytes[5:0]);
        blk[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            sha1_compress();
            pos = 0;
        end
        while (pos < 56)
        begin
            blk[pos] = 8'h00;
            pos++;
        end
        bit_len = 64'(nbytes) << 3;
        for (int i = 0; i < 8; i++)
            blk[56+i] = bit_len[8*(7-i) +: 8];
        sha1_compress();
        digest_out = {chain[0], chain[1], chain[2], chain[3], chain[4]};
        restart_chain();
        return 1'b1;
    endfunction

    function automatic bit sender_pauses();
        case (mode)
            MODE_SENDER_GAPS: return $urandom_range(99) < 53;
            MODE_BOTH_IDLE:   return $urandom_range(99) < 8;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pauses();
        case (mode)
            MODE_RECEIVER_STALLS: return $urandom_range(99) < 53;
            MODE_BOTH_IDLE:       return $urandom_range(99) < 8;
            default:              return 1'b0;
        endcase
    endfunction

    task automatic transfer_item(input logic [7:0] d, input logic nb, input logic last,
                                 input logic typed, input logic [159:0] typed_digest);
        logic [159:0] dig;
        digest_word_t item;
        while (sender_pauses())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        no_byte   <= nb;
        is_last   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (absorb_item(d, nb, last))
        begin
            dig = typed ? typed_digest : digest_out;
            for (int i = 0; i < 5; i++)
            begin
                item.word = dig[159-32*i -: 32];
                item.idx  = 3'(i);
                item.last = (i == 4);
                digest_q.insert(digest_q.size(), item);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sha1_hash_engine_core_tb: errors");
        $finish;
    end

    // Output side: check each transfer, then choose the stall for the next edge.
    initial
    begin
        digest_word_t want;
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h index %0d last %b",
                             $time, digest_word, word_index, last_word);
                    errors++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (digest_word !== want.word || word_index !== want.idx
                        || last_word !== want.last)
                    begin
                        $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 $time, want.word, want.idx, want.last,
                                 digest_word, word_index, last_word);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= receiver_pauses();
        end
    end

    initial
    begin
        int sent;
        int msg;
        int msg_len;
        bit end_marker;
        mode = MODE_STEADY;
        restart_chain();
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        no_byte   <= 1'b0;
        is_last   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
            transfer_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].nb, DIRECTED_ROWS[r].last,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].digest);

        // First two messages: padding spills into a second block, then a block
        // completed by the last byte.
        sent = 0;
        msg = 0;
        while (sent < RANDOM_BYTES)
        begin
            mode = traffic_t'(msg % 4);
            if (msg == 2)
                hold_req = 1'b1;
            case (msg)
                0:       msg_len = 56;
                1:       msg_len = 64;
                default: msg_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                            : $urandom_range(0, 12);
            endcase
            end_marker = (msg_len == 0) || (msg != 1 && $urandom_range(3) == 0);
            for (int i = 0; i < msg_len; i++)
            begin
                if ($urandom_range(9) == 0)
                    transfer_item(8'($urandom), 1'b1, 1'b0, 1'b0, 160'h0);
                transfer_item(8'($urandom), 1'b0, (i == msg_len - 1) && !end_marker,
                              1'b0, 160'h0);
                sent++;
            end
            if (end_marker)
                transfer_item(8'($urandom), 1'b1, 1'b1, 1'b0, 160'h0);
            msg++;
        end
        in_valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("sha1_hash_engine_core_tb: clean");
        else
            $display("sha1_hash_engine_core_tb: errors");
        $finish;
    end

endmodule
